>>> rtl/explicit_free_list_heap_allocator_unit_assert.svh
// Assertion macros for the heap allocator.
`ifndef EXPLICIT_FREE_LIST_HEAP_ALLOCATOR_UNIT_ASSERT_SVH
`define EXPLICIT_FREE_LIST_HEAP_ALLOCATOR_UNIT_ASSERT_SVH

// same-cycle implication
`define EFLA_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define EFLA_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/efla_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package efla_pkg;

    localparam int HEAP_BYTES = 16384;
    localparam int HEAP_WORDS = HEAP_BYTES / 4;
    localparam int WORD_AW    = $clog2(HEAP_WORDS);
    localparam int AW         = 16;       // byte offsets and block sizes
    localparam int DW         = 16;       // stored tag / link word
    localparam int CNT_W      = WORD_AW;

    localparam logic [AW-1:0]    SENTINEL   = AW'(8);
    localparam logic [AW-1:0]    MIN_BLOCK  = AW'(16);
    localparam logic [AW-1:0]    PRO_HDR    = AW'(4);
    localparam logic [AW-1:0]    EPI_INIT   = AW'(12);
    localparam logic [AW-1:0]    BRK_INIT   = AW'(16);
    localparam logic [DW-1:0]    PRO_TAG    = DW'(9);
    localparam logic [DW-1:0]    EPI_TAG    = DW'(1);
    localparam logic [CNT_W-1:0] WALK_LIMIT = CNT_W'(HEAP_BYTES / 16 + 2);
    localparam logic [CNT_W-1:0] CLR_LAST   = CNT_W'(HEAP_WORDS - 1);
    localparam logic [14:0]      CHUNK_RESET = 15'd4096;

    typedef enum logic [1:0] {
        OP_INIT  = 2'd0,
        OP_ALLOC = 2'd1,
        OP_FREE  = 2'd2,
        OP_NOP   = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_ZERO   = 2'd1,
        ST_OOM    = 2'd2,
        ST_NOINIT = 2'd3
    } status_t;

    typedef enum logic [5:0] {
        S_IDLE, S_DECODE,
        S_CLR, S_INIT1, S_INIT2, S_INIT3,
        S_GROW_SZ, S_GROW_CHK, S_GROW_EPI,
        S_FF_RD, S_FF_CHK, S_FF_NX,
        S_PL0, S_PL1, S_PL_RM_S, S_PL_SPL, S_PL_RM_W,
        S_FR0, S_FR1,
        S_M0, S_M1, S_M2, S_M3, S_M_RMN, S_M_TAG,
        S_INS0, S_INS1, S_INS2,
        S_RM0, S_RM1, S_RM2, S_RM3,
        S_TG0, S_TG1,
        S_DONE
    } state_t;

    typedef struct packed {
        state_t step;
    } cmd_t;

    typedef struct packed {
        op_t  op;
        logic initialized;
        logic req_zero;
        logic free_ok;
        logic oom;
        logic clr_last;
        logic walk_end;
        logic q_alloc;
        logic q_fit;
        logic split;
        logic p_used;
        logic n_used;
        logic out_free;
    } stat_t;

endpackage
`default_nettype wire

>>> rtl/efla_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
module efla_ctrl
    import efla_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  in_tvalid,
    output logic       in_tready,
    input  stat_t      stat,
    output cmd_t       cmd
);

    state_t state_reg, state_next;
    state_t rm_ret_reg, rm_ret_next;
    state_t tag_ret_reg, tag_ret_next;
    state_t mrg_ret_reg, mrg_ret_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            rm_ret_reg  <= S_DONE;
            tag_ret_reg <= S_DONE;
            mrg_ret_reg <= S_DONE;
        end
        else
        begin
            state_reg   <= state_next;
            rm_ret_reg  <= rm_ret_next;
            tag_ret_reg <= tag_ret_next;
            mrg_ret_reg <= mrg_ret_next;
        end
    end

    // next state; the three return registers implement remove, tag and merge calls
    always_comb
    begin
        state_next   = state_reg;
        rm_ret_next  = rm_ret_reg;
        tag_ret_next = tag_ret_reg;
        mrg_ret_next = mrg_ret_reg;
        case (state_reg)
            S_IDLE:
                if (in_tvalid)
                    state_next = S_DECODE;
            S_DECODE:
                case (stat.op)
                    OP_INIT:  state_next = S_CLR;
                    OP_ALLOC: state_next = (!stat.initialized || stat.req_zero) ?
                                           S_DONE : S_FF_RD;
                    OP_FREE:  state_next = stat.free_ok ? S_FR0 : S_DONE;
                    default:  state_next = S_DONE;
                endcase
            S_CLR:
                if (stat.clr_last)
                    state_next = S_INIT1;
            S_INIT1:    state_next = S_INIT2;
            S_INIT2:    state_next = S_INIT3;
            S_INIT3:    state_next = S_GROW_SZ;
            S_GROW_SZ:  state_next = S_GROW_CHK;
            S_GROW_CHK:
                if (stat.oom)
                    state_next = S_DONE;
                else
                begin
                    tag_ret_next = S_GROW_EPI;
                    state_next   = S_TG0;
                end
            S_GROW_EPI:
            begin
                mrg_ret_next = (stat.op == OP_ALLOC) ? S_PL0 : S_DONE;
                state_next   = S_M0;
            end
            S_FF_RD:
                state_next = stat.walk_end ? S_GROW_SZ : S_FF_CHK;
            S_FF_CHK:
                if (stat.q_alloc)
                    state_next = S_GROW_SZ;
                else if (stat.q_fit)
                    state_next = S_PL0;
                else
                    state_next = S_FF_NX;
            S_FF_NX:    state_next = S_FF_RD;
            S_PL0:      state_next = S_PL1;
            S_PL1:
            begin
                tag_ret_next = stat.split ? S_PL_RM_S : S_PL_RM_W;
                state_next   = S_TG0;
            end
            S_PL_RM_S:
            begin
                rm_ret_next = S_PL_SPL;
                state_next  = S_RM0;
            end
            S_PL_SPL:
            begin
                tag_ret_next = S_M0;
                mrg_ret_next = S_DONE;
                state_next   = S_TG0;
            end
            S_PL_RM_W:
            begin
                rm_ret_next = S_DONE;
                state_next  = S_RM0;
            end
            S_FR0:      state_next = S_FR1;
            S_FR1:
                if (stat.q_alloc)
                begin
                    tag_ret_next = S_M0;
                    mrg_ret_next = S_DONE;
                    state_next   = S_TG0;
                end
                else
                    state_next = S_DONE;
            S_M0:       state_next = S_M1;
            S_M1:       state_next = S_M2;
            S_M2:       state_next = S_M3;
            S_M3:
                if (stat.p_used && stat.n_used)
                    state_next = S_INS0;
                else
                begin
                    rm_ret_next = (!stat.p_used && !stat.n_used) ? S_M_RMN : S_M_TAG;
                    state_next  = S_RM0;
                end
            S_M_RMN:
            begin
                rm_ret_next = S_M_TAG;
                state_next  = S_RM0;
            end
            S_M_TAG:
            begin
                tag_ret_next = S_INS0;
                state_next   = S_TG0;
            end
            S_INS0:     state_next = S_INS1;
            S_INS1:     state_next = S_INS2;
            S_INS2:     state_next = mrg_ret_reg;
            S_RM0:      state_next = S_RM1;
            S_RM1:      state_next = S_RM2;
            S_RM2:      state_next = S_RM3;
            S_RM3:      state_next = rm_ret_reg;
            S_TG0:      state_next = S_TG1;
            S_TG1:      state_next = tag_ret_reg;
            S_DONE:
                if (stat.out_free)
                    state_next = S_IDLE;
            default:    state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        cmd.step  = state_reg;
        in_tready = (state_reg == S_IDLE);
    end

endmodule
`default_nettype wire

>>> rtl/efla_dpath.sv
`timescale 1ns / 1ps
`default_nettype none
module efla_dpath
    import efla_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  cmd_t             cmd,
    output stat_t            stat,
    input  wire logic        in_tvalid,
    input  wire logic [31:0] in_tdata,
    output logic             out_tvalid,
    input  wire logic        out_tready,
    output logic [15:0]      out_tdata,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [14:0] cfg_data
);

    // heap word memory, single port, registered read
    logic [DW-1:0] mem [HEAP_WORDS];
    logic [DW-1:0] rd_q;
    logic [WORD_AW-1:0] mem_addr;
    logic [AW-1:0]  byte_addr;
    logic           mem_we;
    logic [DW-1:0]  mem_wd;

    // control state
    logic [AW-1:0]  head_reg;
    logic [AW-1:0]  brk_reg;
    logic           init_reg;
    logic [14:0]    chunk_reg;
    logic           ovalid_reg;

    // payload registers
    op_t            op_reg;
    logic [14:0]    req_reg;
    logic [13:0]    addr_reg;
    logic [AW-1:0]  asize_reg, bp_reg, size_reg, csize_reg, nxt_reg, psize_reg, prv_reg;
    logic [AW-1:0]  p_reg, rx_reg, prevl_reg, nextl_reg, result_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic           tag_a_reg, pused_reg;
    status_t        status_reg;
    logic [15:0]    odata_reg;

    logic [AW-1:0]  qsize, asize_in, req_up, bytes, gsize, tag_val;
    logic [13:0]    words;
    logic [14:0]    words_rnd;
    logic [AW:0]    grow_end;
    op_t            op_in;
    logic [14:0]    req_in;

    assign op_in  = op_t'(in_tdata[1:0]);
    assign req_in = in_tdata[16:2];
    assign req_up = AW'({1'b0, req_in}) + AW'(15);
    assign asize_in = (req_in <= 15'd8) ? MIN_BLOCK : {req_up[AW-1:3], 3'b000};

    assign qsize   = {rd_q[DW-1:3], 3'b000};
    assign tag_val = size_reg | AW'(tag_a_reg);

    assign bytes = (op_reg == OP_ALLOC) ?
                   ((asize_reg > AW'(chunk_reg)) ? asize_reg : AW'(chunk_reg)) : MIN_BLOCK;
    assign words     = bytes[AW-1:2];
    assign words_rnd = {1'b0, words} + 15'(words[0]);
    assign gsize     = {words_rnd[13:0], 2'b00};
    assign grow_end  = {1'b0, brk_reg} + {1'b0, size_reg};

    // memory port select
    always_comb
    begin
        byte_addr = bp_reg - AW'(4);
        mem_we    = 1'b0;
        mem_wd    = '0;
        case (cmd.step)
            S_INIT1:    begin byte_addr = PRO_HDR;  mem_we = 1'b1; mem_wd = PRO_TAG; end
            S_INIT2:    begin byte_addr = SENTINEL; mem_we = 1'b1; mem_wd = PRO_TAG; end
            S_INIT3:    begin byte_addr = EPI_INIT; mem_we = 1'b1; mem_wd = EPI_TAG; end
            S_TG0:      begin mem_we = 1'b1; mem_wd = tag_val; end
            S_TG1:
            begin
                byte_addr = bp_reg + size_reg - AW'(8);
                mem_we    = 1'b1;
                mem_wd    = tag_val;
            end
            S_GROW_EPI:
            begin
                byte_addr = bp_reg + size_reg - AW'(4);
                mem_we    = 1'b1;
                mem_wd    = EPI_TAG;
            end
            S_FF_RD:    byte_addr = p_reg - AW'(4);
            S_FF_CHK:   byte_addr = p_reg + AW'(4);
            S_M1:       byte_addr = bp_reg - AW'(8);
            S_M2:       byte_addr = nxt_reg - AW'(4);
            S_INS0:     begin byte_addr = bp_reg + AW'(4); mem_we = 1'b1; mem_wd = head_reg; end
            S_INS1:
            begin
                byte_addr = head_reg;
                mem_we    = (head_reg != SENTINEL);
                mem_wd    = bp_reg;
            end
            S_INS2:     begin byte_addr = bp_reg; mem_we = 1'b1; mem_wd = '0; end
            S_RM0:      byte_addr = rx_reg;
            S_RM1:      byte_addr = rx_reg + AW'(4);
            S_RM2:
            begin
                byte_addr = prevl_reg + AW'(4);
                mem_we    = (prevl_reg != '0);
                mem_wd    = rd_q;
            end
            S_RM3:
            begin
                byte_addr = nextl_reg;
                mem_we    = (nextl_reg != SENTINEL);
                mem_wd    = prevl_reg;
            end
            S_CLR:      mem_we = 1'b1;
            default:    byte_addr = bp_reg - AW'(4);
        endcase
        mem_addr = (cmd.step == S_CLR) ? cnt_reg : byte_addr[WORD_AW+1:2];
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_addr] <= mem_wd;
        rd_q <= mem[mem_addr];
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg   <= SENTINEL;
            brk_reg    <= '0;
            init_reg   <= 1'b0;
            chunk_reg  <= CHUNK_RESET;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
                chunk_reg <= cfg_data;
            if (cmd.step == S_DONE && stat.out_free)
                ovalid_reg <= 1'b1;
            else if (out_tready)
                ovalid_reg <= 1'b0;
            case (cmd.step)
                S_INIT3:
                begin
                    head_reg <= SENTINEL;
                    brk_reg  <= BRK_INIT;
                    init_reg <= 1'b1;
                end
                S_GROW_EPI: brk_reg  <= brk_reg + size_reg;
                S_INS2:     head_reg <= bp_reg;
                S_RM2:
                    if (prevl_reg == '0)
                        head_reg <= rd_q;
                default:    ;
            endcase
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        case (cmd.step)
            S_IDLE:
                if (in_tvalid)
                begin
                    op_reg    <= op_in;
                    req_reg   <= req_in;
                    addr_reg  <= in_tdata[30:17];
                    asize_reg <= asize_in;
                end
            S_DECODE:
            begin
                p_reg      <= head_reg;
                cnt_reg    <= '0;
                bp_reg     <= AW'(addr_reg);
                result_reg <= '0;
                if ((op_reg == OP_ALLOC || op_reg == OP_FREE) && !init_reg)
                    status_reg <= ST_NOINIT;
                else if (op_reg == OP_ALLOC && req_reg == '0)
                    status_reg <= ST_ZERO;
                else
                    status_reg <= ST_OK;
            end
            S_CLR:      cnt_reg <= cnt_reg + CNT_W'(1);
            S_GROW_SZ:  size_reg <= gsize;
            S_GROW_CHK:
            begin
                if (stat.oom)
                    status_reg <= ST_OOM;
                bp_reg    <= brk_reg;
                tag_a_reg <= 1'b0;
            end
            S_FF_CHK:
                if (!stat.q_alloc && stat.q_fit)
                    bp_reg <= p_reg;
            S_FF_NX:
            begin
                p_reg   <= rd_q;
                cnt_reg <= cnt_reg + CNT_W'(1);
            end
            S_PL1:
            begin
                csize_reg  <= qsize;
                result_reg <= bp_reg;
                tag_a_reg  <= 1'b1;
                size_reg   <= stat.split ? asize_reg : qsize;
            end
            S_PL_RM_S,
            S_PL_RM_W:  rx_reg <= bp_reg;
            S_PL_SPL:
            begin
                bp_reg    <= bp_reg + asize_reg;
                size_reg  <= csize_reg - asize_reg;
                tag_a_reg <= 1'b0;
            end
            S_FR1:
            begin
                size_reg  <= qsize;
                tag_a_reg <= 1'b0;
            end
            S_M1:
            begin
                size_reg <= qsize;
                nxt_reg  <= bp_reg + qsize;
            end
            S_M2:
            begin
                psize_reg <= qsize;
                prv_reg   <= bp_reg - qsize;
                pused_reg <= rd_q[0] || (qsize == '0);
            end
            S_M3:
                if (pused_reg && !rd_q[0])
                begin
                    size_reg <= size_reg + qsize;
                    rx_reg   <= nxt_reg;
                end
                else if (!pused_reg && rd_q[0])
                begin
                    size_reg <= size_reg + psize_reg;
                    rx_reg   <= prv_reg;
                    bp_reg   <= prv_reg;
                end
                else if (!pused_reg && !rd_q[0])
                begin
                    size_reg <= size_reg + psize_reg + qsize;
                    rx_reg   <= prv_reg;
                    bp_reg   <= prv_reg;
                end
            S_M_RMN:    rx_reg    <= nxt_reg;
            S_M_TAG:    tag_a_reg <= 1'b0;
            S_RM1:      prevl_reg <= rd_q;
            S_RM2:      nextl_reg <= rd_q;
            S_DONE:
                if (stat.out_free)
                    odata_reg <= {status_reg, result_reg[13:0]};
            default:    ;
        endcase
    end

    always_comb
    begin
        stat.op          = op_reg;
        stat.initialized = init_reg;
        stat.req_zero    = (req_reg == '0);
        stat.free_ok     = init_reg && (addr_reg[2:0] == 3'b000) &&
                           (AW'(addr_reg) >= MIN_BLOCK) && (AW'(addr_reg) < brk_reg);
        stat.oom         = (grow_end > (AW + 1)'(HEAP_BYTES));
        stat.clr_last    = (cnt_reg == CLR_LAST);
        stat.walk_end    = (cnt_reg == WALK_LIMIT);
        stat.q_alloc     = rd_q[0];
        stat.q_fit       = (qsize >= asize_reg);
        stat.split       = ((qsize - asize_reg) >= MIN_BLOCK);
        stat.p_used      = pused_reg;
        stat.n_used      = rd_q[0];
        stat.out_free    = !ovalid_reg || out_tready;
    end

    assign out_tvalid = ovalid_reg;
    assign out_tdata  = odata_reg;
    assign cfg_ready  = 1'b1;

endmodule
`default_nettype wire

>>> rtl/explicit_free_list_heap_allocator_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// Boundary-tag heap allocator with an explicit LIFO free list (first fit).
// s_axis carries one command per transaction: init, allocate, free or nop.
// m_axis returns one result per command: payload offset and status.
// cfg_* writes the heap growth chunk in bytes; write it only while idle.
// Sequence: decode, then a read per list node visited, then place/merge;
//   a free whose address is rejected goes straight to its result.
//   Init clears the whole 4096-word heap memory, one word per cycle.
// One command at a time; the single heap memory port sets the pace.
// A finished result sits in the output register; the next command is
//   accepted while it waits. If m_axis_tready stays low, the following
//   result holds in its final step until the register frees up.
// Reset: free head = 8, break = 0, heap not initialized, chunk = 4096.
//   Heap memory contents are not reset; init clears them.
`include "explicit_free_list_heap_allocator_unit_assert.svh"
module explicit_free_list_heap_allocator_unit
    import efla_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [31:0] s_axis_tdata,   // [1:0] opcode, [16:2] request_size,
                                             // [30:17] block_addr, [31] zero
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [15:0]      m_axis_tdata,   // [13:0] result_addr, [15:14] status
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [14:0] cfg_data        // chunk_bytes
);

    cmd_t  cmd;
    stat_t stat;

    // sequencer: walks init, alloc, free and their merge/remove/tag steps
    efla_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_tvalid (s_axis_tvalid),
        .in_tready (s_axis_tready),
        .stat      (stat),
        .cmd       (cmd)
    );

    // heap memory, list pointers, size arithmetic and output register
    efla_dpath u_dpath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .stat       (stat),
        .in_tvalid  (s_axis_tvalid),
        .in_tdata   (s_axis_tdata),
        .out_tvalid (m_axis_tvalid),
        .out_tready (m_axis_tready),
        .out_tdata  (m_axis_tdata),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_data   (cfg_data)
    );

    // one command in flight: busy right after a transaction is taken
    `EFLA_ASSERT_NXT(a_busy_after_accept, s_axis_tvalid && s_axis_tready,
        !s_axis_tready, "input accepted while a command is in flight")

    // a nonzero address only comes with ok status
    `EFLA_ASSERT_IMP(a_addr_only_ok, m_axis_tvalid && (m_axis_tdata[13:0] != 14'd0),
        m_axis_tdata[15:14] == ST_OK, "nonzero result address with error status")

    // the final step hands its result to the output register and frees the input
    `EFLA_ASSERT_NXT(a_done_loads_out, (cmd.step == S_DONE) && stat.out_free,
        m_axis_tvalid && s_axis_tready, "result not delivered after final step")

endmodule
`default_nettype wire

>>> verif/tb_explicit_free_list_heap_allocator_unit.sv
`timescale 1ns / 1ps
`default_nettype none
module tb_explicit_free_list_heap_allocator_unit;
    import efla_pkg::*;

    localparam int HEAP_SZ   = 16384;
    localparam int WALK_MAX  = HEAP_SZ / 16 + 2;
    localparam int MIN_BLK   = 16;
    localparam int LIST_END  = 8;

    // one command as queued for the driver; a free may take its address from
    // the live blocks at the moment it goes out on the bus
    typedef struct {
        op_t         op;
        logic [14:0] req;
        logic [13:0] addr;
        bit          pick_live;
        bit          after_drain;
    } heap_cmd_t;

    typedef struct {
        logic [13:0] addr;
        status_t     st;
    } heap_result_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata = '0;   // [1:0] opcode, [16:2] request_size,
                                      // [30:17] block_addr, [31] zero
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;        // [13:0] result_addr, [15:14] status
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [14:0] cfg_data = 15'd4096;

    explicit_free_list_heap_allocator_unit i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data)
    );

    always #10 clk = ~clk;

    // ------------------------------------------------------------------
    // Heap shadow: word memory, list head, break, init flag, chunk size
    // ------------------------------------------------------------------
    bit [31:0] shadow_mem [0:HEAP_SZ/4-1];
    bit [31:0] shadow_head = LIST_END;
    bit [31:0] shadow_brk = 0;
    bit        shadow_inited = 1'b0;
    bit [31:0] shadow_chunk = 4096;
    bit [31:0] live_blocks [$];     // payload offsets currently allocated

    heap_cmd_t    cmd_q [$];
    heap_result_t result_q [$];
    int           mismatches = 0;
    int           idle_mode = 0;    // 0 none, 1 sender, 2 receiver, 3 both
    int           hold_asks = 0;    // long receiver hold-off requests

    function automatic bit [31:0] mem_rd(bit [31:0] a);
        return shadow_mem[a[13:2]];
    endfunction

    function automatic void mem_wr(bit [31:0] a, bit [31:0] v);
        shadow_mem[a[13:2]] = v;
    endfunction

    function automatic bit [31:0] blk_size(bit [31:0] bp);
        return mem_rd(bp - 4) & ~32'h7;
    endfunction

    function automatic bit blk_used(bit [31:0] bp);
        bit [31:0] w;
        w = mem_rd(bp - 4);
        return w[0];
    endfunction

    function automatic void put_tags(bit [31:0] bp, bit [31:0] size, bit [31:0] used);
        mem_wr(bp - 4, size | used);
        mem_wr(bp + size - 8, size | used);
    endfunction

    function automatic void push_free(bit [31:0] bp);
        mem_wr(bp + 4, shadow_head);
        if (shadow_head != LIST_END)
            mem_wr(shadow_head, bp);
        mem_wr(bp, 0);
        shadow_head = bp;
    endfunction

    function automatic void unlink_free(bit [31:0] bp);
        bit [31:0] prv;
        bit [31:0] nxt;
        prv = mem_rd(bp);
        nxt = mem_rd(bp + 4);
        if (prv != 0)
            mem_wr(prv + 4, nxt);
        else
            shadow_head = nxt;
        if (nxt != LIST_END)
            mem_wr(nxt, prv);
    endfunction

    // join with free neighbours, then put the result at the list head
    function automatic bit [31:0] coalesce(bit [31:0] bp);
        bit [31:0] size;
        bit [31:0] nxt;
        bit [31:0] psize;
        bit [31:0] prv;
        bit        n_used;
        bit        p_used;
        size   = blk_size(bp);
        nxt    = bp + size;
        psize  = mem_rd(bp - 8) & ~32'h7;
        prv    = bp - psize;
        n_used = blk_used(nxt);
        p_used = mem_rd(bp - 8) & 32'h1 || psize == 0;
        if (p_used && !n_used)
        begin
            size += blk_size(nxt);
            unlink_free(nxt);
            put_tags(bp, size, 0);
        end
        else if (!p_used && n_used)
        begin
            size += psize;
            unlink_free(prv);
            bp = prv;
            put_tags(bp, size, 0);
        end
        else if (!p_used && !n_used)
        begin
            size += psize + blk_size(nxt);
            unlink_free(prv);
            unlink_free(nxt);
            bp = prv;
            put_tags(bp, size, 0);
        end
        push_free(bp);
        return bp;
    endfunction

    function automatic bit [31:0] extend_break(bit [31:0] bytes);
        bit [31:0] words;
        bit [31:0] size;
        bit [31:0] bp;
        words = bytes >> 2;
        if (words[0])
            words++;
        size = words * 4;
        if (longint'(shadow_brk) + longint'(size) > HEAP_SZ)
            return 0;
        bp = shadow_brk;
        put_tags(bp, size, 0);
        mem_wr(bp + size - 4, 1);
        shadow_brk += size;
        return coalesce(bp);
    endfunction

    function automatic bit [31:0] first_fit(bit [31:0] asize);
        bit [31:0] p;
        p = shadow_head;
        for (int n = 0; n < WALK_MAX && !blk_used(p); n++)
        begin
            if (blk_size(p) >= asize)
                return p;
            p = mem_rd(p + 4);
        end
        return 0;
    endfunction

    function automatic void carve(bit [31:0] bp, bit [31:0] asize);
        bit [31:0] csize;
        bit [31:0] rest;
        csize = blk_size(bp);
        if (csize - asize >= MIN_BLK)
        begin
            put_tags(bp, asize, 1);
            unlink_free(bp);
            put_tags(bp + asize, csize - asize, 0);
            rest = coalesce(bp + asize);
        end
        else
        begin
            put_tags(bp, csize, 1);
            unlink_free(bp);
        end
    endfunction

    function automatic void drop_live(bit [31:0] a);
        foreach (live_blocks[i])
            if (live_blocks[i] == a)
            begin
                live_blocks.delete(i);
                return;
            end
    endfunction

    // expected result of one command, shadow state updated along the way
    function automatic heap_result_t heap_step(heap_cmd_t c);
        heap_result_t r;
        bit [31:0]    asize;
        bit [31:0]    bp;
        bit [31:0]    a;
        r.addr = '0;
        r.st   = ST_OK;
        a      = c.addr;
        case (c.op)
            OP_INIT:
            begin
                foreach (shadow_mem[i])
                    shadow_mem[i] = 0;
                mem_wr(4, 9);
                mem_wr(8, 9);
                mem_wr(12, 1);
                shadow_head   = LIST_END;
                shadow_brk    = 16;
                shadow_inited = 1'b1;
                live_blocks.delete();
                bp = extend_break(MIN_BLK);
            end
            OP_ALLOC:
            begin
                if (!shadow_inited)
                    r.st = ST_NOINIT;
                else if (c.req == 0)
                    r.st = ST_ZERO;
                else
                begin
                    asize = (c.req <= 8) ? MIN_BLK : 8 * ((32'(c.req) + 15) / 8);
                    bp = first_fit(asize);
                    if (bp == 0)
                        bp = extend_break(asize > shadow_chunk ? asize : shadow_chunk);
                    if (bp == 0)
                        r.st = ST_OOM;
                    else
                    begin
                        carve(bp, asize);
                        r.addr = bp[13:0];
                        live_blocks.push_back(bp);
                    end
                end
            end
            OP_FREE:
            begin
                if (!shadow_inited)
                    r.st = ST_NOINIT;
                else if (a[2:0] == 0 && a >= 16 && a < shadow_brk && blk_used(a))
                begin
                    put_tags(a, blk_size(a), 0);
                    bp = coalesce(a);
                    drop_live(a);
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Driver: presents queued commands, predicts each accepted one
    // ------------------------------------------------------------------
    heap_cmd_t on_bus;

    always @(posedge clk)
    begin
        heap_cmd_t nxt;
        bit        gap;
        if (rst_n)
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                result_q.push_back(heap_step(on_bus));
                void'(cmd_q.pop_front());
            end
            gap = (idle_mode == 1 && $urandom_range(99) < 50) ||
                  (idle_mode == 3 && $urandom_range(99) < 37);
            if (s_axis_tvalid && !s_axis_tready)
                ;   // hold the transaction until it is taken
            else if (cmd_q.size() > 0 && !gap &&
                     !(cmd_q[0].after_drain && result_q.size() > 0))
            begin
                nxt = cmd_q[0];
                if (nxt.pick_live && live_blocks.size() > 0)
                    nxt.addr = live_blocks[$urandom_range(live_blocks.size() - 1)][13:0];
                on_bus <= nxt;
                s_axis_tdata  <= {1'b0, nxt.addr, nxt.req, nxt.op};
                s_axis_tvalid <= 1'b1;
            end
            else
                s_axis_tvalid <= 1'b0;
        end
    end

    // Receiver: random stalls plus an occasional long hold-off
    int hold_seen = 0;
    int hold_left = 0;

    always @(posedge clk)
    begin
        if (hold_seen != hold_asks)
        begin
            hold_seen <= hold_asks;
            hold_left <= 400;
            m_axis_tready <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            m_axis_tready <= 1'b0;
        end
        else if (idle_mode == 2)
            m_axis_tready <= $urandom_range(99) >= 50;
        else if (idle_mode == 3)
            m_axis_tready <= $urandom_range(99) >= 37;
        else
            m_axis_tready <= 1'b1;
    end

    // Monitor: every result against the oldest expectation
    always @(posedge clk)
    begin
        heap_result_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (result_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: addr %0d status %0d",
                             m_axis_tdata[13:0], m_axis_tdata[15:14]);
            end
            else
            begin
                want = result_q.pop_front();
                if (m_axis_tdata[13:0] !== want.addr || m_axis_tdata[15:14] !== want.st)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: addr exp %0d got %0d, status exp %0d got %0d",
                                 want.addr, m_axis_tdata[13:0], want.st,
                                 m_axis_tdata[15:14]);
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    function automatic heap_cmd_t mk(op_t op, int req, int addr, bit pick);
        heap_cmd_t c;
        c.op          = op;
        c.req         = 15'(req);
        c.addr        = 14'(addr);
        c.pick_live   = pick;
        c.after_drain = 1'b0;
        return c;
    endfunction

    function automatic heap_cmd_t random_cmd();
        int roll;
        int sz;
        roll = $urandom_range(99);
        if (roll < 46)
        begin
            sz = $urandom_range(99);
            if (sz < 2)
                sz = 0;
            else if (sz < 70)
                sz = $urandom_range(64, 1);
            else if (sz < 95)
                sz = $urandom_range(1024, 65);
            else
                sz = $urandom_range(16384, 1025);
            return mk(OP_ALLOC, sz, $urandom_range(16383), 0);
        end
        else if (roll < 86)
            return mk(OP_FREE, $urandom_range(16384), 0, 1);
        else if (roll < 95)
            return mk(OP_FREE, $urandom_range(16384), $urandom_range(16383), 0);
        else if (roll < 99)
            return mk(OP_NOP, $urandom_range(16384), $urandom_range(16383), 0);
        else
            return mk(OP_INIT, $urandom_range(16384), $urandom_range(16383), 0);
    endfunction

    task automatic wait_idle();
        while (cmd_q.size() > 0 || result_q.size() > 0 || s_axis_tvalid)
            @(posedge clk);
        repeat (60) @(posedge clk);
    endtask

    task automatic set_chunk(int v);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= 15'(v);
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        shadow_chunk = v;
    endtask

    int        chunk_plan [8] = '{16, 16384, 64, 4096, 1000, 100, 256, 8192};
    heap_cmd_t c;

    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // directed: commands before init, edge sizes, bad frees, coalescing
        cmd_q.push_back(mk(OP_NOP, 0, 0, 0));
        cmd_q.push_back(mk(OP_ALLOC, 5, 0, 0));
        cmd_q.push_back(mk(OP_FREE, 0, 16, 0));
        cmd_q.push_back(mk(OP_INIT, 16384, 16383, 0));
        cmd_q.push_back(mk(OP_ALLOC, 0, 0, 0));
        cmd_q.push_back(mk(OP_ALLOC, 1, 0, 0));
        cmd_q.push_back(mk(OP_ALLOC, 8, 0, 0));
        cmd_q.push_back(mk(OP_ALLOC, 9, 0, 0));
        cmd_q.push_back(mk(OP_ALLOC, 16384, 0, 0));
        cmd_q.push_back(mk(OP_ALLOC, 16383, 0, 0));
        cmd_q.push_back(mk(OP_ALLOC, 100, 0, 0));
        cmd_q.push_back(mk(OP_FREE, 0, 13, 0));
        cmd_q.push_back(mk(OP_FREE, 0, 8, 0));
        cmd_q.push_back(mk(OP_FREE, 0, 16376, 0));
        cmd_q.push_back(mk(OP_FREE, 0, 0, 0));
        for (int i = 0; i < 4; i++)
            cmd_q.push_back(mk(OP_ALLOC, 24, 0, 0));
        for (int i = 0; i < 4; i++)
            cmd_q.push_back(mk(OP_FREE, 0, 0, 1));
        cmd_q.push_back(mk(OP_FREE, 0, 24, 0));
        cmd_q.push_back(mk(OP_ALLOC, 4000, 0, 0));
        wait_idle();

        for (int ph = 0; ph < 8; ph++)
        begin
            set_chunk(chunk_plan[ph]);
            idle_mode = ph % 4;
            if (ph % 2 == 0)
                cmd_q.push_back(mk(OP_INIT, 0, 0, 0));
            for (int i = 0; i < 104; i++)
            begin
                c = random_cmd();
                // one mid-phase pause that lets everything drain first
                if (i == 50)
                    c.after_drain = 1'b1;
                cmd_q.push_back(c);
            end
            // fill up the block while results back up
            if (ph == 1 || ph == 4)
                hold_asks = hold_asks + 1;
            wait_idle();
        end

        repeat (200) @(posedge clk);
        if (mismatches == 0 && result_q.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    initial
    begin
        #500ms;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
`default_nettype wire
